FILE: design/utv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the UTF-8 text validator.
// Used by utv_track and utf8_text_validator; depends on nothing.

package utv_pkg;

    localparam int MAX_TEXT_BYTES_DEF = 65535;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH = 2'd1;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [1:0] VERDICT_OK      = 2'd0;
    localparam logic [1:0] VERDICT_LENGTH  = 2'd1;
    localparam logic [1:0] VERDICT_NUL     = 2'd2;
    localparam logic [1:0] VERDICT_BAD_UTF = 2'd3;

    localparam logic [2:0] RANGE_ANY   = 3'd0;
    localparam logic [2:0] RANGE_A0_BF = 3'd1;
    localparam logic [2:0] RANGE_80_9F = 3'd2;
    localparam logic [2:0] RANGE_90_BF = 3'd3;
    localparam logic [2:0] RANGE_80_8F = 3'd4;

    localparam logic [7:0] BYTE_NUL       = 8'h00;
    localparam logic [7:0] BYTE_ASCII_MAX = 8'h7f;
    localparam logic [7:0] CONT_MASK      = 8'hc0;
    localparam logic [7:0] CONT_TAG       = 8'h80;
    localparam logic [7:0] LEAD2_LO       = 8'hc2;
    localparam logic [7:0] LEAD2_HI       = 8'hdf;
    localparam logic [7:0] LEAD3_LO       = 8'he0;
    localparam logic [7:0] LEAD3_HI       = 8'hef;
    localparam logic [7:0] LEAD3_ED       = 8'hed;
    localparam logic [7:0] LEAD4_LO       = 8'hf0;
    localparam logic [7:0] LEAD4_HI       = 8'hf4;
    localparam logic [7:0] CONT_80        = 8'h80;
    localparam logic [7:0] CONT_8F        = 8'h8f;
    localparam logic [7:0] CONT_90        = 8'h90;
    localparam logic [7:0] CONT_9F        = 8'h9f;
    localparam logic [7:0] CONT_A0        = 8'ha0;
    localparam logic [7:0] CONT_BF        = 8'hbf;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [16:0] text_length;
    } t_out_item;

    typedef struct packed {
        logic [1:0] pending;
        logic [2:0] next_range;
        logic       nul_seen;
        logic       utf8_bad;
    } t_text_flags;

endpackage

`default_nettype wire

FILE: design/utv_track.sv
`timescale 1ns / 1ps
`default_nettype none
// Per-text state: saturating byte counter, NUL flag and strict UTF-8 decoder.
// Depends on utv_pkg.

module utv_track #(
    parameter int MAX_TEXT_BYTES = utv_pkg::MAX_TEXT_BYTES_DEF,
    parameter int CNT_W          = $clog2(MAX_TEXT_BYTES + 2)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_take_byte,
    input  wire logic               i_clear,
    input  wire logic [7:0]         i_byte,
    output      logic [CNT_W-1:0]   o_count,
    output      utv_pkg::t_text_flags o_flags
);
    import utv_pkg::*;

    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(MAX_TEXT_BYTES + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_text_flags      r_flags;
    t_text_flags      n_flags;
    logic             w_in_range;
    logic             w_as_lead;

    always_comb begin
        unique case (r_flags.next_range)
            RANGE_A0_BF: w_in_range = (i_byte >= CONT_A0) && (i_byte <= CONT_BF);
            RANGE_80_9F: w_in_range = (i_byte >= CONT_80) && (i_byte <= CONT_9F);
            RANGE_90_BF: w_in_range = (i_byte >= CONT_90) && (i_byte <= CONT_BF);
            RANGE_80_8F: w_in_range = (i_byte >= CONT_80) && (i_byte <= CONT_8F);
            default:     w_in_range = (i_byte & CONT_MASK) == CONT_TAG;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_flags   = r_flags;
        w_as_lead = 1'b0;
        if (i_clear) begin
            n_count = '0;
            n_flags = '0;
        end else if (i_take_byte) begin
            w_as_lead = 1'b1;
            if (r_count < COUNT_CAP) begin
                n_count = r_count + 1'b1;
            end
            if (i_byte == BYTE_NUL) begin
                n_flags.nul_seen = 1'b1;
            end
            if (r_flags.pending != 2'd0) begin
                n_flags.next_range = RANGE_ANY;
                if (w_in_range) begin
                    n_flags.pending = r_flags.pending - 2'd1;
                    w_as_lead       = 1'b0;
                end else begin
                    n_flags.utf8_bad = 1'b1;
                    n_flags.pending  = 2'd0;
                end
            end
            if (w_as_lead) begin
                priority if (i_byte <= BYTE_ASCII_MAX) begin
                    n_flags.pending = n_flags.pending;
                end else if (i_byte >= LEAD2_LO && i_byte <= LEAD2_HI) begin
                    n_flags.pending    = 2'd1;
                    n_flags.next_range = RANGE_ANY;
                end else if (i_byte >= LEAD3_LO && i_byte <= LEAD3_HI) begin
                    n_flags.pending = 2'd2;
                    if (i_byte == LEAD3_LO) begin
                        n_flags.next_range = RANGE_A0_BF;
                    end else if (i_byte == LEAD3_ED) begin
                        n_flags.next_range = RANGE_80_9F;
                    end else begin
                        n_flags.next_range = RANGE_ANY;
                    end
                end else if (i_byte >= LEAD4_LO && i_byte <= LEAD4_HI) begin
                    n_flags.pending = 2'd3;
                    if (i_byte == LEAD4_LO) begin
                        n_flags.next_range = RANGE_90_BF;
                    end else if (i_byte == LEAD4_HI) begin
                        n_flags.next_range = RANGE_80_8F;
                    end else begin
                        n_flags.next_range = RANGE_ANY;
                    end
                end else begin
                    n_flags.utf8_bad = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_flags <= '0;
        end else begin
            r_count <= n_count;
            r_flags <= n_flags;
        end
    end

    assign o_count = r_count;
    assign o_flags = r_flags;

    a_count_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_CAP)
        else $error("byte counter passed its cap");

    a_range_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flags.next_range != RANGE_ANY) |-> (r_flags.pending != 2'd0))
        else $error("restricted range without an owed continuation");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> (r_count == '0) && (r_flags == '0))
        else $error("text state not cleared after end beat");

endmodule

`default_nettype wire

FILE: design/utf8_text_validator.sv
`timescale 1ns / 1ps
`default_nettype none
// UTF-8 text validator top level: input register, text tracker, verdict and result register.
// Depends on utv_pkg and utv_track.
//
// A text arrives on the input channel as byte beats (kind 0) closed by one end
// beat (kind 1). Byte beats give no result. The end beat gives one result beat
// with the verdict (length out of range, NUL present, invalid UTF-8, or ok, in
// that priority) and the saturated byte count, and the text state clears.
// The input channel takes one beat per clock cycle while o_in_stall is low.
// A beat is held in the input register, where it updates the text state; an
// end beat then loads the result register, which drives o_out_valid.
// The result register frees as its beat is taken, so a new end beat can follow
// every cycle. When the receiver stalls with a result held, byte beats keep
// flowing; an end beat waits in the input register and o_in_stall rises.
// The user must write min_length and max_length through the configuration port only
// while the block is idle; the block itself does not enforce this. Reset clears the
// text state, both valids and the registers to min_length 0 and max_length 65535.

module utf8_text_validator #(
    parameter int MAX_TEXT_BYTES = utv_pkg::MAX_TEXT_BYTES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output      logic                              o_in_stall,
    input  wire utv_pkg::t_in_item                 i_in_item,
    output      logic                              o_out_valid,
    input  wire logic                              i_out_stall,
    output      utv_pkg::t_out_item                o_out_item,
    input  wire logic                              i_cfg_we,
    input  wire logic [utv_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [utv_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import utv_pkg::*;

    localparam int CNT_W = $clog2(MAX_TEXT_BYTES + 2);
    localparam int CMP_W = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;

    logic [CFG_DATA_W-1:0] r_min_length;
    logic [CFG_DATA_W-1:0] r_max_length;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;

    logic             w_out_free;
    logic             w_advance;
    logic             w_is_end;
    logic [CNT_W-1:0] w_count;
    t_text_flags      w_flags;
    logic [CMP_W-1:0] w_count_x;
    logic             w_len_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= '0;
            r_max_length <= '1;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_MIN_LENGTH) begin
                r_min_length <= i_cfg_data;
            end
            if (i_cfg_index == REG_MAX_LENGTH) begin
                r_max_length <= i_cfg_data;
            end
        end
    end

    assign w_is_end   = r_in_item.kind == KIND_END;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && (!w_is_end || w_out_free);
    assign o_in_stall = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    utv_track #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES),
        .CNT_W          (CNT_W)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take_byte (w_advance && !w_is_end),
        .i_clear     (w_advance && w_is_end),
        .i_byte      (r_in_item.data_byte),
        .o_count     (w_count),
        .o_flags     (w_flags)
    );

    assign w_count_x = CMP_W'(w_count);
    assign w_len_bad = (w_count_x < CMP_W'(r_min_length))
                    || (w_count_x > CMP_W'(r_max_length))
                    || (w_count_x > CMP_W'(MAX_TEXT_BYTES));

    always_comb begin
        n_out_item.text_length = 17'(w_count);
        priority if (w_len_bad) begin
            n_out_item.verdict = VERDICT_LENGTH;
        end else if (w_flags.nul_seen) begin
            n_out_item.verdict = VERDICT_NUL;
        end else if (w_flags.utf8_bad || (w_flags.pending != 2'd0)) begin
            n_out_item.verdict = VERDICT_BAD_UTF;
        end else begin
            n_out_item.verdict = VERDICT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_advance && w_is_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_is_end) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire
